FILE: hw/rtl/sbsv_pkg.sv
// Package with the shared types, codes and helper functions of the script blob validator.
`timescale 1ns / 1ps
`default_nettype none
package sbsv_pkg;

	// Field kinds, also used as the parser phase
	typedef enum logic [3:0] {
		PH_MAGIC   = 4'd0,
		PH_VERSION = 4'd1,
		PH_COUNT   = 4'd2,
		PH_IDLEN   = 4'd3,
		PH_ID      = 4'd4,
		PH_NAMELEN = 4'd5,
		PH_NAME    = 4'd6,
		PH_SRCLEN  = 4'd7,
		PH_SRC     = 4'd8,
		PH_DONE    = 4'd9
	} phase_t;

	// Fault codes
	typedef enum logic [2:0] {
		F_NONE      = 3'd0,
		F_MAGIC     = 3'd1,
		F_VERSION   = 3'd2,
		F_COUNT     = 3'd3,
		F_SRCLEN    = 3'd4,
		F_BADID     = 3'd5,
		F_TRUNCATED = 3'd6,
		F_TRAILING  = 3'd7
	} fault_t;

	// Register indexes of the configuration channel
	localparam logic [7:0] REG_MAX_ENTRIES    = 8'd0;
	localparam logic [7:0] REG_MAX_ID_LENGTH  = 8'd1;
	localparam logic [7:0] REG_MAX_SRC_LENGTH = 8'd2;

	localparam logic [7:0]  RST_MAX_ENTRIES    = 8'd16;
	localparam logic [7:0]  RST_MAX_ID_LENGTH  = 8'd32;
	localparam logic [31:0] RST_MAX_SRC_LENGTH = 32'd16384;

	// Magic and version bytes, allowed id characters
	localparam logic [7:0] CHAR_S      = 8'h53;
	localparam logic [7:0] CHAR_B      = 8'h42;
	localparam logic [7:0] VERSION_ONE = 8'h01;
	localparam logic [7:0] CHAR_LC_A   = 8'h61;
	localparam logic [7:0] CHAR_LC_Z   = 8'h7a;
	localparam logic [7:0] CHAR_D0     = 8'h30;
	localparam logic [7:0] CHAR_D9     = 8'h39;
	localparam logic [7:0] CHAR_DASH   = 8'h2d;
	localparam logic [7:0] CHAR_UNDER  = 8'h5f;

	// Configuration limits
	typedef struct packed {
		logic [7:0]  max_entries;
		logic [7:0]  max_id_length;
		logic [31:0] max_src_length;
	} cfg_t;

	// Parser state
	typedef struct packed {
		phase_t      phase;
		logic [31:0] remaining;
		logic [31:0] acc;
		logic [7:0]  entries_left;
		logic [7:0]  entry_count;
		logic        id_ok;
		fault_t      fault;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:        PH_MAGIC,
		remaining:    32'd0,
		acc:          32'd0,
		entries_left: 8'd0,
		entry_count:  8'd0,
		id_ok:        1'b1,
		fault:        F_NONE
	};

	// One result item
	typedef struct packed {
		phase_t     kind;
		logic [7:0] entry_number;
		logic       failed;
		fault_t     fault;
		logic       verdict;
		logic       accepted;
	} result_t;

	// Keep the first fault only
	function automatic fault_t raise_fault(fault_t cur, fault_t code);
		return (cur == F_NONE) ? code : cur;
	endfunction

	function automatic logic id_char_allowed(logic [7:0] c);
		return ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) ||
			((c >= CHAR_D0) && (c <= CHAR_D9)) ||
			(c == CHAR_DASH) || (c == CHAR_UNDER);
	endfunction

	// Close an entry: report a bad id, advance counters, pick the next phase
	function automatic state_t finish_entry(state_t s);
		state_t r;
		r = s;
		if (!s.id_ok) begin
			r.fault = raise_fault(s.fault, F_BADID);
		end
		r.entry_count  = s.entry_count + 8'd1;
		r.entries_left = s.entries_left - 8'd1;
		r.id_ok        = 1'b1;
		r.phase        = (r.entries_left == 8'd0) ? PH_DONE : PH_IDLEN;
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sbsv_parse.sv
// Byte parser: state registers and the single-pass next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none
module sbsv_parse (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             take,
	input  wire logic [7:0]       data_byte,
	input  wire logic             end_of_blob,
	input  wire sbsv_pkg::cfg_t   cfg,
	output sbsv_pkg::result_t     res,
	output sbsv_pkg::state_t      state
);
	import sbsv_pkg::*;

	state_t      st_q;
	state_t      nx;
	logic [7:0]  want;
	logic [31:0] acc_next;
	logic [31:0] rem_dec;
	phase_t      kind;

	// Work out the effect of one byte on the parser state
	always_comb begin
		nx       = st_q;
		kind     = st_q.phase;
		want     = (st_q.remaining == 32'd1) ? CHAR_B : CHAR_S;
		acc_next = {st_q.acc[23:0], data_byte};
		rem_dec  = (st_q.remaining != 32'd0) ? (st_q.remaining - 32'd1) : st_q.remaining;
		case (st_q.phase)
			PH_MAGIC: begin
				if (data_byte != want) begin
					nx.fault = raise_fault(nx.fault, F_MAGIC);
				end
				if (st_q.remaining >= 32'd2) begin
					nx.remaining = 32'd0;
					nx.phase     = PH_VERSION;
				end else begin
					nx.remaining = st_q.remaining + 32'd1;
				end
			end
			PH_VERSION: begin
				if (data_byte != VERSION_ONE) begin
					nx.fault = raise_fault(nx.fault, F_VERSION);
				end
				nx.phase = PH_COUNT;
			end
			PH_COUNT: begin
				if (data_byte > cfg.max_entries) begin
					nx.fault = raise_fault(nx.fault, F_COUNT);
				end
				nx.entries_left = data_byte;
				nx.phase        = (data_byte == 8'd0) ? PH_DONE : PH_IDLEN;
			end
			PH_IDLEN: begin
				nx.id_ok     = (data_byte != 8'd0) && (data_byte <= cfg.max_id_length);
				nx.remaining = {24'd0, data_byte};
				nx.phase     = (data_byte == 8'd0) ? PH_NAMELEN : PH_ID;
			end
			PH_ID: begin
				if (!id_char_allowed(data_byte)) begin
					nx.id_ok = 1'b0;
				end
				nx.remaining = st_q.remaining - 32'd1;
				if (nx.remaining == 32'd0) begin
					nx.phase = PH_NAMELEN;
				end
			end
			PH_NAMELEN: begin
				nx.acc = 32'd0;
				if (data_byte == 8'd0) begin
					nx.remaining = 32'd4;
					nx.phase     = PH_SRCLEN;
				end else begin
					nx.remaining = {24'd0, data_byte};
					nx.phase     = PH_NAME;
				end
			end
			PH_NAME: begin
				nx.remaining = st_q.remaining - 32'd1;
				if (nx.remaining == 32'd0) begin
					nx.remaining = 32'd4;
					nx.acc       = 32'd0;
					nx.phase     = PH_SRCLEN;
				end
			end
			PH_SRCLEN: begin
				nx.acc       = acc_next;
				nx.remaining = rem_dec;
				if (rem_dec == 32'd0) begin
					if (acc_next > cfg.max_src_length) begin
						nx.fault = raise_fault(nx.fault, F_SRCLEN);
					end
					nx.remaining = acc_next;
					if (acc_next == 32'd0) begin
						nx = finish_entry(nx);
					end else begin
						nx.phase = PH_SRC;
					end
				end
			end
			PH_SRC: begin
				nx.remaining = st_q.remaining - 32'd1;
				if (nx.remaining == 32'd0) begin
					nx = finish_entry(nx);
				end
			end
			default: begin
				kind     = PH_DONE;
				nx.fault = raise_fault(nx.fault, F_TRAILING);
			end
		endcase
		// Flag an early end of blob
		if (end_of_blob && (nx.phase != PH_DONE)) begin
			nx.fault = raise_fault(nx.fault, F_TRUNCATED);
		end
	end

	// Assemble the result item
	always_comb begin
		res.kind         = kind;
		res.entry_number = st_q.entry_count;
		res.failed       = (nx.fault != F_NONE);
		res.fault        = nx.fault;
		res.verdict      = end_of_blob;
		res.accepted     = end_of_blob && (nx.fault == F_NONE);
	end

	// Advance on each accepted byte; restart after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (take) begin
			st_q <= end_of_blob ? STATE_RESET : nx;
		end
	end

	assign state = st_q;

endmodule
`default_nettype wire

FILE: hw/rtl/sbsv_out_reg.sv
// Result register between the parser and the output stream.
`timescale 1ns / 1ps
`default_nettype none
module sbsv_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire sbsv_pkg::result_t in_res,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sbsv_pkg::result_t      out_res
);
	import sbsv_pkg::*;

	logic    valid_q;
	result_t res_q;

	// Take a new result when empty or when the held one leaves this cycle
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Hold payload while stalled
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/script_blob_stream_validator_core.sv
// Top level of the script blob stream validator: ports, configuration registers, checks.
//
// Channel  Direction  Handshake               Payload
// s_*      in         s_tvalid / s_tready     s_tdata = data_byte, s_tlast = end_of_blob
// m_*      out        m_tvalid / m_tready     m_tdata = result fields, m_tuser = field_kind,
//                                             m_tlast = verdict_valid
// cfg_*    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per cycle unless the output stalls: each accepted byte updates the parser state and
// its result lands in the output register in the same cycle. s_tready is low only while a
// result waits in the output register and m_tready is low. Reset clears the parser to the
// magic phase and loads the default limits.
// The parser restarts by itself after each final byte; limits are kept.
`timescale 1ns / 1ps
`default_nettype none
module script_blob_stream_validator_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] entry_number, [8] failed, [11:9] fault_code,
	                                    // [12] accepted, [15:13] zero
	output logic [3:0]       m_tuser,   // [3:0] field_kind
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import sbsv_pkg::*;

	cfg_t    cfg_q;
	result_t res;
	result_t out_res;
	state_t  state;
	logic    take;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_entries    <= RST_MAX_ENTRIES;
			cfg_q.max_id_length  <= RST_MAX_ID_LENGTH;
			cfg_q.max_src_length <= RST_MAX_SRC_LENGTH;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MAX_ENTRIES:    cfg_q.max_entries    <= cfg_data[7:0];
				REG_MAX_ID_LENGTH:  cfg_q.max_id_length  <= cfg_data[7:0];
				REG_MAX_SRC_LENGTH: cfg_q.max_src_length <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign take = s_tvalid && s_tready;

	sbsv_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (s_tdata),
		.end_of_blob (s_tlast),
		.cfg         (cfg_q),
		.res         (res),
		.state       (state)
	);

	sbsv_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_res    (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Pack the result transaction
	assign m_tdata = {3'd0, out_res.accepted, out_res.fault, out_res.failed,
		out_res.entry_number};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.verdict;

	// Acceptance only on a clean final result
	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_res.accepted |-> out_res.verdict && (out_res.fault == F_NONE))
		else $error("accepted without clean verdict");

	// Failed flag agrees with the fault code
	a_failed_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_res.failed == (out_res.fault != F_NONE)))
		else $error("failed flag and fault code disagree");

	// Parser restarts after a final byte
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && s_tlast |=> (state.phase == PH_MAGIC) && (state.fault == F_NONE))
		else $error("parser did not restart after final byte");

	// Input is never stalled while the output register is empty
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output register");

endmodule
`default_nettype wire
